### src/pltkb_pkg.sv
// Shared types, constants and helper functions of the point light blend unit.
`timescale 1ns / 1ps

package pltkb_pkg;

   localparam logic OPC_WRITE = 1'b0;
   localparam logic OPC_QUERY = 1'b1;

   localparam logic [4:0]  Q_T    = 5'd17;
   localparam logic [4:0]  Q_UNIT = 5'd16;
   localparam logic [4:0]  Q_TINT = 5'd8;

   localparam logic [31:0] DIR_MIN_LEN   = 32'd16;
   localparam logic [16:0] UNIT_MAX      = 17'd32767;
   localparam logic [29:0] FULL_STRENGTH = 30'd65536;
   localparam logic [7:0]  TINT_MAX      = 8'd255;

   typedef struct packed {
      logic [31:0] pos_x;
      logic [31:0] pos_y;
      logic [30:0] radius;
      logic [15:0] intensity;
      logic [23:0] colour;
   } entry_type;

   typedef struct packed {
      logic [23:0]        weight;
      logic signed [15:0] ux;
      logic signed [15:0] uy;
      logic [23:0]        colour;
   } kept_type;

   typedef struct packed {
      logic        start;
      logic [47:0] num;
      logic [31:0] den;
      logic [4:0]  qbits;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [16:0] quot;
   } div_rsp_type;

   typedef struct packed {
      logic        start;
      logic [63:0] value;
   } sqrt_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] root;
   } sqrt_rsp_type;

   function automatic logic signed [15:0] unit_comp(input logic [16:0] q, input logic neg);
      logic [14:0] m;
      m = (q > UNIT_MAX) ? 15'h7fff : q[14:0];
      return neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
   endfunction

   function automatic logic [7:0] tint_sat(input logic [16:0] q);
      return (q > 17'(TINT_MAX)) ? TINT_MAX : q[7:0];
   endfunction

endpackage

### src/pltkb_table.sv
// Light table memory, one entry per light, registered read port.
`timescale 1ns / 1ps

module pltkb_table import pltkb_pkg::*; #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  entry_type     wdata,
   input  logic          re,
   input  logic [AW-1:0] raddr,
   output entry_type     rdata
);

   entry_type mem [DEPTH];
   entry_type rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### src/pltkb_sqrt.sv
// Floor integer square root of a 64-bit value, two radicand bits per cycle.
`timescale 1ns / 1ps

module pltkb_sqrt import pltkb_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  sqrt_req_type req,
   output sqrt_rsp_type rsp
);

   logic [63:0] v_ff, v_in;
   logic [33:0] rem_ff, rem_in;
   logic [31:0] root_ff, root_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [35:0] rem4;
   logic [35:0] trial;
   logic        ge;

   always_comb begin
      rem4    = {rem_ff, v_ff[63:62]};
      trial   = {2'b00, root_ff, 2'b01};
      ge      = rem4 >= trial;
      v_in    = v_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         v_in    = req.value;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = 6'd32;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         v_in    = {v_ff[61:0], 2'b00};
         rem_in  = ge ? 34'(rem4 - trial) : rem4[33:0];
         root_in = {root_ff[30:0], ge};
         cnt_in  = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff    <= v_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign rsp.done = done_ff;
   assign rsp.root = root_ff;

endmodule

### src/pltkb_div.sv
// Restoring divider, one quotient bit per cycle, quotient length set per request.
`timescale 1ns / 1ps

module pltkb_div import pltkb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic [47:0] num_ff, num_in;
   logic [31:0] den_ff, den_in;
   logic [31:0] rem_ff, rem_in;
   logic [16:0] q_ff, q_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [5:0]  bit_idx;
   logic [32:0] rem2;
   logic        ge;
   logic [47:0] head;

   always_comb begin
      bit_idx = 6'(cnt_ff) - 6'd1;
      rem2    = {rem_ff, num_ff[bit_idx]};
      ge      = rem2 >= {1'b0, den_ff};
      head    = req.num >> req.qbits;
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         num_in  = req.num;
         den_in  = req.den;
         rem_in  = head[31:0];
         q_in    = '0;
         cnt_in  = req.qbits;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? 32'(rem2 - {1'b0, den_ff}) : rem2[31:0];
         q_in   = {q_ff[15:0], ge};
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quot = q_ff;

endmodule

### src/point_light_top_k_blend_unit.sv
// Top level of the point light blend unit: sequencer, top-k list and accumulators.
//
//  channel | direction | handshake          | transaction
//  req     | in        | req_valid/ready    | table write or lighting query
//  rsp     | out       | rsp_valid/ready    | lighting result of one query
//  csr     | in        | csr_valid/ready    | light_count register write
//
// A table write is taken in the idle state. A query runs, per light in range, a square root
// and up to three divider passes (distance ratio, then the two unit components), all on one shared
// divider and one root unit, then blends the kept lights with one more root and up to five divisions.
// Reset is synchronous; it clears control state only, table contents stay undefined.
// A finished result waits in the output register; the next transaction is taken meanwhile
// and stalls only at its own result if the previous one is still not taken.
`timescale 1ns / 1ps

module point_light_top_k_blend_unit import pltkb_pkg::*; #(
   parameter int NUM_LIGHTS = 64,
   parameter int TOP_K      = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_opcode,
   input  logic [5:0]         req_light_index,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic [30:0]        req_light_radius,
   input  logic [15:0]        req_light_intensity,
   input  logic [7:0]         req_light_red,
   input  logic [7:0]         req_light_green,
   input  logic [7:0]         req_light_blue,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [16:0]        rsp_strength,
   output logic signed [15:0] rsp_dir_x,
   output logic signed [15:0] rsp_dir_y,
   output logic [7:0]         rsp_tint_red,
   output logic [7:0]         rsp_tint_green,
   output logic [7:0]         rsp_tint_blue,
   output logic               rsp_lit,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [6:0]         csr_light_count
);

   localparam int AW = (NUM_LIGHTS > 1) ? $clog2(NUM_LIGHTS) : 1;
   localparam int CW = (AW + 1 > 7) ? AW + 1 : 7;
   localparam int IW = (TOP_K > 1) ? $clog2(TOP_K) : 1;
   localparam int KW = $clog2(TOP_K + 1);

   typedef enum logic [25:0] {
      S_IDLE  = 26'h0000001,
      S_RD    = 26'h0000002,
      S_DIFF  = 26'h0000004,
      S_SQX   = 26'h0000008,
      S_SQY   = 26'h0000010,
      S_SQS   = 26'h0000020,
      S_SQRT  = 26'h0000040,
      S_DT    = 26'h0000080,
      S_W1    = 26'h0000100,
      S_W2    = 26'h0000200,
      S_UX    = 26'h0000400,
      S_UY    = 26'h0000800,
      S_INS   = 26'h0001000,
      S_NEXT  = 26'h0002000,
      S_ACC   = 26'h0004000,
      S_FIN   = 26'h0008000,
      S_FSQX  = 26'h0010000,
      S_FSQY  = 26'h0020000,
      S_FSQS  = 26'h0040000,
      S_FSQRT = 26'h0080000,
      S_FDX   = 26'h0100000,
      S_FDY   = 26'h0200000,
      S_TR    = 26'h0400000,
      S_TG    = 26'h0800000,
      S_TB    = 26'h1000000,
      S_OUT   = 26'h2000000
   } state_type;

   state_type state_ff, state_in;

   logic [6:0]         count_ff, count_in;
   logic [CW-1:0]      n_ff, n_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic [KW-1:0]      nkept_ff, nkept_in;
   logic [KW-1:0]      k_ff, k_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic signed [31:0] px_ff, px_in;
   logic signed [31:0] py_ff, py_in;
   logic [31:0]        ax_ff, ax_in;
   logic [31:0]        ay_ff, ay_in;
   logic               xneg_ff, xneg_in;
   logic               yneg_ff, yneg_in;
   logic [63:0]        sqa_ff, sqa_in;
   logic [63:0]        sqb_ff, sqb_in;
   logic [31:0]        dist_ff, dist_in;
   logic [16:0]        t_ff, t_in;
   logic [32:0]        tt_ff, tt_in;
   logic [23:0]        w_ff, w_in;
   logic signed [15:0] ux_ff, ux_in;
   logic signed [15:0] uy_ff, uy_in;
   kept_type           kept_ff [TOP_K];
   kept_type           kept_in [TOP_K];
   logic [29:0]        total_ff, total_in;
   logic signed [45:0] sx_ff, sx_in;
   logic signed [45:0] sy_ff, sy_in;
   logic [37:0]        sr_ff, sr_in;
   logic [37:0]        sg_ff, sg_in;
   logic [37:0]        sb_ff, sb_in;
   logic signed [15:0] dirx_ff, dirx_in;
   logic signed [15:0] diry_ff, diry_in;
   logic [7:0]         tr_ff, tr_in;
   logic [7:0]         tg_ff, tg_in;
   logic [7:0]         tb_ff, tb_in;
   logic [16:0]        o_strength_ff, o_strength_in;
   logic signed [15:0] o_dirx_ff, o_dirx_in;
   logic signed [15:0] o_diry_ff, o_diry_in;
   logic [7:0]         o_tr_ff, o_tr_in;
   logic [7:0]         o_tg_ff, o_tg_in;
   logic [7:0]         o_tb_ff, o_tb_in;
   logic               o_lit_ff, o_lit_in;

   entry_type          rd;
   entry_type          wr_entry;
   logic               wr_en;
   logic [31:0]        wr_wide;
   logic [AW-1:0]      wr_addr;
   logic               rd_en;

   div_req_type        div_req;
   div_rsp_type        div_rsp;
   sqrt_req_type       sqrt_req;
   sqrt_rsp_type       sqrt_rsp;

   logic signed [32:0] dx;
   logic signed [32:0] dy;
   logic [31:0]        sq_op;
   logic [63:0]        sq_prod;
   logic [33:0]        tt_full;
   logic [48:0]        w_full;
   kept_type           ke;
   kept_type           cand;
   logic signed [40:0] xw_prod;
   logic signed [40:0] yw_prod;
   logic [31:0]        rw_prod;
   logic [31:0]        gw_prod;
   logic [31:0]        bw_prod;
   logic [45:0]        sx_mag;
   logic [45:0]        sy_mag;
   logic [TOP_K-1:0]   gt;
   logic               req_take;

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign req_take  = req_valid && req_ready;

   assign wr_wide  = 32'(req_light_index);
   assign wr_addr  = wr_wide[AW-1:0];
   assign wr_en    = req_take && (req_opcode == OPC_WRITE) && (wr_wide < 32'(NUM_LIGHTS));
   assign wr_entry = '{pos_x: req_pos_x, pos_y: req_pos_y, radius: req_light_radius,
                       intensity: req_light_intensity,
                       colour: {req_light_red, req_light_green, req_light_blue}};
   assign rd_en    = (state_ff == S_RD);

   pltkb_table #(.DEPTH(NUM_LIGHTS), .AW(AW)) u_table (
      .clock (clock),
      .we    (wr_en),
      .waddr (wr_addr),
      .wdata (wr_entry),
      .re    (rd_en),
      .raddr (idx_ff[AW-1:0]),
      .rdata (rd)
   );

   pltkb_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .req   (sqrt_req),
      .rsp   (sqrt_rsp)
   );

   pltkb_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   always_comb begin
      dx      = $signed({rd.pos_x[31], rd.pos_x}) - $signed({px_ff[31], px_ff});
      dy      = $signed({rd.pos_y[31], rd.pos_y}) - $signed({py_ff[31], py_ff});
      case (state_ff)
         S_SQX:   sq_op = ax_ff;
         S_SQY:   sq_op = ay_ff;
         S_FSQX:  sq_op = ax_ff;
         default: sq_op = ay_ff;
      endcase
      sq_prod = sq_op * sq_op;
      tt_full = t_ff * t_ff;
      w_full  = tt_ff * rd.intensity;
      ke      = kept_ff[k_ff[IW-1:0]];
      xw_prod = $signed(ke.ux) * $signed({1'b0, ke.weight});
      yw_prod = $signed(ke.uy) * $signed({1'b0, ke.weight});
      rw_prod = ke.colour[23:16] * ke.weight;
      gw_prod = ke.colour[15:8] * ke.weight;
      bw_prod = ke.colour[7:0] * ke.weight;
      sx_mag  = sx_ff[45] ? 46'(-sx_ff) : 46'(sx_ff);
      sy_mag  = sy_ff[45] ? 46'(-sy_ff) : 46'(sy_ff);
      cand    = '{weight: w_ff, ux: ux_ff, uy: uy_ff, colour: rd.colour};
   end

   always_comb begin
      int pj;
      for (int j = 0; j < TOP_K; j++) begin
         gt[j] = (KW'(j) >= nkept_ff) || (cand.weight > kept_ff[j].weight);
      end
      for (int j = 0; j < TOP_K; j++) begin
         pj = (j == 0) ? 0 : j - 1;
         if (!gt[j]) begin
            kept_in[j] = kept_ff[j];
         end else if (j == 0 || !gt[pj]) begin
            kept_in[j] = cand;
         end else begin
            kept_in[j] = kept_ff[pj];
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      n_in          = n_ff;
      idx_in        = idx_ff;
      nkept_in      = nkept_ff;
      k_in          = k_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      px_in         = px_ff;
      py_in         = py_ff;
      ax_in         = ax_ff;
      ay_in         = ay_ff;
      xneg_in       = xneg_ff;
      yneg_in       = yneg_ff;
      sqa_in        = sqa_ff;
      sqb_in        = sqb_ff;
      dist_in       = dist_ff;
      t_in          = t_ff;
      tt_in         = tt_ff;
      w_in          = w_ff;
      ux_in         = ux_ff;
      uy_in         = uy_ff;
      total_in      = total_ff;
      sx_in         = sx_ff;
      sy_in         = sy_ff;
      sr_in         = sr_ff;
      sg_in         = sg_ff;
      sb_in         = sb_ff;
      dirx_in       = dirx_ff;
      diry_in       = diry_ff;
      tr_in         = tr_ff;
      tg_in         = tg_ff;
      tb_in         = tb_ff;
      o_strength_in = o_strength_ff;
      o_dirx_in     = o_dirx_ff;
      o_diry_in     = o_diry_ff;
      o_tr_in       = o_tr_ff;
      o_tg_in       = o_tg_ff;
      o_tb_in       = o_tb_ff;
      o_lit_in      = o_lit_ff;
      div_req       = '0;
      sqrt_req      = '0;

      if (csr_valid && csr_ready) begin
         count_in = csr_light_count;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_take && req_opcode == OPC_QUERY) begin
               px_in    = req_pos_x;
               py_in    = req_pos_y;
               n_in     = (32'(count_ff) > 32'(NUM_LIGHTS)) ? CW'(NUM_LIGHTS) : CW'(count_ff);
               idx_in   = '0;
               nkept_in = '0;
               k_in     = '0;
               total_in = '0;
               sx_in    = '0;
               sy_in    = '0;
               sr_in    = '0;
               sg_in    = '0;
               sb_in    = '0;
               dirx_in  = '0;
               diry_in  = '0;
               tr_in    = TINT_MAX;
               tg_in    = TINT_MAX;
               tb_in    = TINT_MAX;
               state_in = (n_in == '0) ? S_ACC : S_RD;
            end
         end
         S_RD: begin
            state_in = S_DIFF;
         end
         S_DIFF: begin
            xneg_in = dx[32];
            yneg_in = dy[32];
            ax_in   = dx[32] ? 32'(-dx) : dx[31:0];
            ay_in   = dy[32] ? 32'(-dy) : dy[31:0];
            if (rd.radius == '0 || ax_in >= {1'b0, rd.radius} ||
                ay_in >= {1'b0, rd.radius}) begin
               state_in = S_NEXT;
            end else begin
               state_in = S_SQX;
            end
         end
         S_SQX: begin
            sqa_in   = sq_prod;
            state_in = S_SQY;
         end
         S_SQY: begin
            sqb_in   = sq_prod;
            state_in = S_SQS;
         end
         S_SQS: begin
            sqrt_req.start = 1'b1;
            sqrt_req.value = sqa_ff + sqb_ff;
            state_in       = S_SQRT;
         end
         S_SQRT: begin
            if (sqrt_rsp.done) begin
               dist_in = sqrt_rsp.root;
               if (sqrt_rsp.root >= {1'b0, rd.radius}) begin
                  state_in = S_NEXT;
               end else begin
                  div_req.start = 1'b1;
                  div_req.num   = {17'd0, rd.radius - sqrt_rsp.root[30:0]} << 16;
                  div_req.den   = {1'b0, rd.radius};
                  div_req.qbits = Q_T;
                  state_in      = S_DT;
               end
            end
         end
         S_DT: begin
            if (div_rsp.done) begin
               t_in     = div_rsp.quot;
               state_in = S_W1;
            end
         end
         S_W1: begin
            tt_in    = tt_full[32:0];
            state_in = S_W2;
         end
         S_W2: begin
            w_in = w_full[47:24];
            if (w_in == '0) begin
               state_in = S_NEXT;
            end else if (dist_ff == '0) begin
               ux_in    = '0;
               uy_in    = '0;
               state_in = S_INS;
            end else begin
               div_req.start = 1'b1;
               div_req.num   = {1'b0, ax_ff, 15'd0};
               div_req.den   = dist_ff;
               div_req.qbits = Q_UNIT;
               state_in      = S_UX;
            end
         end
         S_UX: begin
            if (div_rsp.done) begin
               ux_in         = unit_comp(div_rsp.quot, xneg_ff);
               div_req.start = 1'b1;
               div_req.num   = {1'b0, ay_ff, 15'd0};
               div_req.den   = dist_ff;
               div_req.qbits = Q_UNIT;
               state_in      = S_UY;
            end
         end
         S_UY: begin
            if (div_rsp.done) begin
               uy_in    = unit_comp(div_rsp.quot, yneg_ff);
               state_in = S_INS;
            end
         end
         S_INS: begin
            if (nkept_ff != KW'(TOP_K)) begin
               nkept_in = nkept_ff + KW'(1);
            end
            state_in = S_NEXT;
         end
         S_NEXT: begin
            idx_in   = idx_ff + CW'(1);
            state_in = (idx_in == n_ff) ? S_ACC : S_RD;
         end
         S_ACC: begin
            if (k_ff == nkept_ff) begin
               state_in = (nkept_ff == '0) ? S_OUT : S_FIN;
            end else begin
               total_in = total_ff + 30'(ke.weight);
               sx_in    = sx_ff + 46'(xw_prod);
               sy_in    = sy_ff + 46'(yw_prod);
               sr_in    = sr_ff + 38'(rw_prod);
               sg_in    = sg_ff + 38'(gw_prod);
               sb_in    = sb_ff + 38'(bw_prod);
               k_in     = k_ff + KW'(1);
            end
         end
         S_FIN: begin
            ax_in    = sx_mag[43:12];
            ay_in    = sy_mag[43:12];
            xneg_in  = sx_ff[45];
            yneg_in  = sy_ff[45];
            state_in = S_FSQX;
         end
         S_FSQX: begin
            sqa_in   = sq_prod;
            state_in = S_FSQY;
         end
         S_FSQY: begin
            sqb_in   = sq_prod;
            state_in = S_FSQS;
         end
         S_FSQS: begin
            sqrt_req.start = 1'b1;
            sqrt_req.value = sqa_ff + sqb_ff;
            state_in       = S_FSQRT;
         end
         S_FSQRT: begin
            if (sqrt_rsp.done) begin
               dist_in       = sqrt_rsp.root;
               div_req.start = 1'b1;
               if (sqrt_rsp.root > DIR_MIN_LEN) begin
                  div_req.num   = {1'b0, ax_ff, 15'd0};
                  div_req.den   = sqrt_rsp.root;
                  div_req.qbits = Q_UNIT;
                  state_in      = S_FDX;
               end else begin
                  div_req.num   = 48'(sr_ff);
                  div_req.den   = 32'(total_ff);
                  div_req.qbits = Q_TINT;
                  state_in      = S_TR;
               end
            end
         end
         S_FDX: begin
            if (div_rsp.done) begin
               dirx_in       = unit_comp(div_rsp.quot, xneg_ff);
               div_req.start = 1'b1;
               div_req.num   = {1'b0, ay_ff, 15'd0};
               div_req.den   = dist_ff;
               div_req.qbits = Q_UNIT;
               state_in      = S_FDY;
            end
         end
         S_FDY: begin
            if (div_rsp.done) begin
               diry_in       = unit_comp(div_rsp.quot, yneg_ff);
               div_req.start = 1'b1;
               div_req.num   = 48'(sr_ff);
               div_req.den   = 32'(total_ff);
               div_req.qbits = Q_TINT;
               state_in      = S_TR;
            end
         end
         S_TR: begin
            if (div_rsp.done) begin
               tr_in         = tint_sat(div_rsp.quot);
               div_req.start = 1'b1;
               div_req.num   = 48'(sg_ff);
               div_req.den   = 32'(total_ff);
               div_req.qbits = Q_TINT;
               state_in      = S_TG;
            end
         end
         S_TG: begin
            if (div_rsp.done) begin
               tg_in         = tint_sat(div_rsp.quot);
               div_req.start = 1'b1;
               div_req.num   = 48'(sb_ff);
               div_req.den   = 32'(total_ff);
               div_req.qbits = Q_TINT;
               state_in      = S_TB;
            end
         end
         S_TB: begin
            if (div_rsp.done) begin
               tb_in    = tint_sat(div_rsp.quot);
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               o_strength_in = (total_ff > FULL_STRENGTH) ? 17'(FULL_STRENGTH)
                                                          : total_ff[16:0];
               o_dirx_in     = dirx_ff;
               o_diry_in     = diry_ff;
               o_tr_in       = tr_ff;
               o_tg_in       = tg_ff;
               o_tb_in       = tb_ff;
               o_lit_in      = (nkept_ff != '0);
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         n_ff         <= '0;
         idx_ff       <= '0;
         nkept_ff     <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         n_ff         <= n_in;
         idx_ff       <= idx_in;
         nkept_ff     <= nkept_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      px_ff         <= px_in;
      py_ff         <= py_in;
      ax_ff         <= ax_in;
      ay_ff         <= ay_in;
      xneg_ff       <= xneg_in;
      yneg_ff       <= yneg_in;
      sqa_ff        <= sqa_in;
      sqb_ff        <= sqb_in;
      dist_ff       <= dist_in;
      t_ff          <= t_in;
      tt_ff         <= tt_in;
      w_ff          <= w_in;
      ux_ff         <= ux_in;
      uy_ff         <= uy_in;
      total_ff      <= total_in;
      sx_ff         <= sx_in;
      sy_ff         <= sy_in;
      sr_ff         <= sr_in;
      sg_ff         <= sg_in;
      sb_ff         <= sb_in;
      dirx_ff       <= dirx_in;
      diry_ff       <= diry_in;
      tr_ff         <= tr_in;
      tg_ff         <= tg_in;
      tb_ff         <= tb_in;
      o_strength_ff <= o_strength_in;
      o_dirx_ff     <= o_dirx_in;
      o_diry_ff     <= o_diry_in;
      o_tr_ff       <= o_tr_in;
      o_tg_ff       <= o_tg_in;
      o_tb_ff       <= o_tb_in;
      o_lit_ff      <= o_lit_in;
      if (state_ff == S_INS) begin
         kept_ff <= kept_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_strength   = o_strength_ff;
   assign rsp_dir_x      = o_dirx_ff;
   assign rsp_dir_y      = o_diry_ff;
   assign rsp_tint_red   = o_tr_ff;
   assign rsp_tint_green = o_tg_ff;
   assign rsp_tint_blue  = o_tb_ff;
   assign rsp_lit        = o_lit_ff;

endmodule

### src/pltkb_checker.sv
// Port-level checks of the point light blend unit and their binding.
`timescale 1ns / 1ps

module pltkb_checker import pltkb_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               req_opcode,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [16:0]        rsp_strength,
   input logic signed [15:0] rsp_dir_x,
   input logic signed [15:0] rsp_dir_y,
   input logic [7:0]         rsp_tint_red,
   input logic [7:0]         rsp_tint_green,
   input logic [7:0]         rsp_tint_blue,
   input logic               rsp_lit
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_strength))
      else $error("result dropped or changed while stalled");

   a_strength_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_strength <= 17'd65536)
      else $error("strength above full scale");

   a_unlit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_lit |-> rsp_strength == '0 && rsp_dir_x == '0 && rsp_dir_y == '0
         && rsp_tint_red == TINT_MAX && rsp_tint_green == TINT_MAX
         && rsp_tint_blue == TINT_MAX)
      else $error("unlit result not at defaults");

   a_lit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_lit |-> rsp_strength != '0)
      else $error("lit result with zero strength");

   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_opcode == OPC_QUERY |=> !req_ready)
      else $error("query did not start");

endmodule

bind point_light_top_k_blend_unit pltkb_checker u_pltkb_checker (.*);
